FILE: rtl/bda_pkg.sv
`default_nettype none

package bda_pkg;

    // Fixed payload widths of the two channels
    localparam int NUMBER_BITS = 64;
    localparam int CHAR_BITS   = 6;
    localparam int BCD_BITS    = 4;

    // ASCII code of the character '0', and the largest decimal digit
    localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'h30;
    localparam logic [BCD_BITS-1:0]  BCD_MAX    = 4'd9;
    // A digit at or above this is corrected by adding three before each shift
    localparam logic [BCD_BITS-1:0]  DABBLE_MIN = 4'd5;
    localparam logic [BCD_BITS-1:0]  DABBLE_ADD = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } bda_state_t;

    // Per-cycle command shared by every digit cell
    typedef struct packed {
        logic clear;   // zero the digit
        logic dabble;  // correct and shift one binary bit in
        logic move;    // take the neighbour's digit (shift one digit up)
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/bda_number_if.sv
`default_nettype none

interface bda_number_if
    import bda_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [NUMBER_BITS-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

`default_nettype wire

FILE: rtl/bda_digit_if.sv
`default_nettype none

interface bda_digit_if
    import bda_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CHAR_BITS-1:0] digit_char;
    logic                 last;

    modport source (output valid, output digit_char, output last, input ready);
    modport sink   (input valid, input digit_char, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/bda_cell.sv
`default_nettype none

// One BCD digit of the double-dabble chain.
module bda_cell
    import bda_pkg::*;
(
    input  wire logic                clk,
    input  wire cell_ctrl_t          ctrl,
    input  wire logic                carry_in,
    input  wire logic [BCD_BITS-1:0] digit_in,
    output logic                     carry_out,
    output logic [BCD_BITS-1:0]      digit
);

    logic [BCD_BITS-1:0] digit_reg;
    logic [BCD_BITS-1:0] digit_next;
    logic [BCD_BITS-1:0] adjusted;

    // Correct the digit so that the shift carries into the next decade
    assign adjusted  = (digit_reg >= DABBLE_MIN) ? digit_reg + DABBLE_ADD : digit_reg;
    assign carry_out = adjusted[BCD_BITS-1];
    assign digit     = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adjusted[BCD_BITS-2:0], carry_in};
        end
        else if (ctrl.move)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

`default_nettype wire

FILE: rtl/binary_to_decimal_ascii_top.sv
`default_nettype none

// Channel      Dir  Payload                      Word
// number_ch    in   number[63:0]                 one binary value (low NUMBER_WIDTH bits used)
// digit_ch     out  digit_char[5:0], last        one ASCII digit, most significant first
//
// Steps: take a value, shift it bit by bit through the digit chain, then move each digit
// position up to the top cell in turn (leading zeros are dropped there, not sent).
// The conversion is a bit-serial shift through the chain of BCD cells.
// Reset clears the sequencer and the output valid; the digit cells need none.
// A stall on digit_ch holds the output word and freezes the digit chain; the next value
// is taken while the final digit still waits in the output register.
module binary_to_decimal_ascii_top
    import bda_pkg::*;
#(
    parameter int NUMBER_WIDTH = 64
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    bda_number_if.sink   number_ch,
    bda_digit_if.source  digit_ch
);

    // Decimal digits needed for NUMBER_WIDTH bits: floor(W * log10(2)) + 1
    localparam int NDIG   = (NUMBER_WIDTH * 1233) / 4096 + 1;
    localparam int CNT_W  = $clog2(NUMBER_WIDTH);
    localparam int DCNT_W = $clog2(NDIG + 1);

    bda_state_t state_reg;
    bda_state_t state_next;

    logic [NUMBER_WIDTH-1:0] bin_reg;
    logic [NUMBER_WIDTH-1:0] bin_next;
    logic [CNT_W-1:0]        bit_cnt_reg;
    logic [CNT_W-1:0]        bit_cnt_next;
    logic [DCNT_W-1:0]       dig_cnt_reg;
    logic [DCNT_W-1:0]       dig_cnt_next;
    logic                    started_reg;
    logic                    started_next;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [CHAR_BITS-1:0]    out_char_reg;
    logic [CHAR_BITS-1:0]    out_char_next;
    logic                    out_last_reg;
    logic                    out_last_next;

    logic                    accept;
    logic                    out_free;
    logic                    bits_done;
    logic                    top_zero;
    logic                    skip;
    logic                    out_load;
    logic                    final_digit;
    cell_ctrl_t              cell_ctrl;

    logic [NDIG:0]                carry;
    logic [NDIG-1:0][BCD_BITS-1:0] digit_q;
    logic [BCD_BITS-1:0]          top_digit;

    // ------------------------------------------------------------------
    // Chain of BCD cells: cell 0 is the units digit and takes the binary
    // MSB; the top cell's carry is never set for an in-range value.
    // ------------------------------------------------------------------
    assign carry[0] = bin_reg[NUMBER_WIDTH-1];

    for (genvar i = 0; i < NDIG; i++)
    begin : g_cell
        logic [BCD_BITS-1:0] below;
        if (i == 0)
        begin : g_first
            assign below = '0;
        end
        else
        begin : g_rest
            assign below = digit_q[i-1];
        end

        bda_cell u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl),
            .carry_in  (carry[i]),
            .digit_in  (below),
            .carry_out (carry[i+1]),
            .digit     (digit_q[i])
        );
    end

    assign top_digit = digit_q[NDIG-1];

    // ------------------------------------------------------------------
    // Handshake helpers
    // ------------------------------------------------------------------
    assign out_free    = !out_valid_reg || digit_ch.ready;
    assign bits_done   = (bit_cnt_reg == CNT_W'(NUMBER_WIDTH - 1));
    assign top_zero    = (top_digit == '0);
    assign final_digit = (dig_cnt_reg == DCNT_W'(1));

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (number_ch.valid)
                begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (bits_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free && final_digit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        number_ch.ready  = 1'b0;
        cell_ctrl        = '0;
        skip             = 1'b0;
        out_load         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                number_ch.ready = 1'b1;
                cell_ctrl.clear = 1'b1;
            end
            ST_CONVERT:
            begin
                cell_ctrl.dabble = 1'b1;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    // Drop leading zeros, but always keep the units digit
                    skip           = top_zero && !started_reg && !final_digit;
                    out_load       = !skip;
                    cell_ctrl.move = 1'b1;
                end
            end
            default:
            begin
                cell_ctrl = '0;
            end
        endcase
    end

    assign accept = number_ch.valid && number_ch.ready;

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        bin_next     = bin_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        started_next = started_reg;
        if (accept)
        begin
            bin_next     = number_ch.number[NUMBER_WIDTH-1:0];
            bit_cnt_next = '0;
        end
        else if (cell_ctrl.dabble)
        begin
            bin_next     = {bin_reg[NUMBER_WIDTH-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + CNT_W'(1);
            if (bits_done)
            begin
                dig_cnt_next = DCNT_W'(NDIG);
                started_next = 1'b0;
            end
        end
        else if (cell_ctrl.move)
        begin
            dig_cnt_next = dig_cnt_reg - DCNT_W'(1);
            started_next = started_reg || out_load;
        end
    end

    // Output register: load a digit, or drop valid once the word is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_char_next  = ASCII_ZERO | {{(CHAR_BITS-BCD_BITS){1'b0}}, top_digit};
            out_last_next  = final_digit;
        end
        else if (digit_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
            started_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
            started_reg   <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign digit_ch.valid      = out_valid_reg;
    assign digit_ch.digit_char = out_char_reg;
    assign digit_ch.last       = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_CONVERT)
        else $error("accepted value did not start a conversion");

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> dig_cnt_reg != '0)
        else $error("digit count ran out while emitting");

    a_top_bcd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> top_digit <= BCD_MAX)
        else $error("top cell holds a non-decimal digit");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CONVERT |-> !carry[NDIG])
        else $error("digit chain overflowed during a conversion");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && final_digit) |=> state_reg == ST_IDLE && out_last_reg)
        else $error("final digit did not end the value");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (out_char_reg >= ASCII_ZERO
            && out_char_reg <= (ASCII_ZERO | {{(CHAR_BITS-BCD_BITS){1'b0}}, BCD_MAX})))
        else $error("output character is not a decimal digit");

endmodule

`default_nettype wire

FILE: bench/binary_to_decimal_ascii_top_test.sv
module binary_to_decimal_ascii_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bda_pkg::*;

    // Configuration under test. Only the low NUMBER_WIDTH bits of a number count.
    localparam int NUMBER_WIDTH = 64;
    localparam int MAX_DIGITS   = 20;
    localparam logic [NUMBER_BITS-1:0] WIDTH_MASK =
        {NUMBER_BITS{1'b1}} >> (NUMBER_BITS - NUMBER_WIDTH);

    // Time for one value: the shifts through the digit chain, then the digit positions
    localparam int DIGIT_LATENCY  = NUMBER_WIDTH + MAX_DIGITS + 1;
    // Cycles with no word moving on either channel before the run is abandoned.
    // The longest honest quiet stretch is a long sender gap followed by a whole
    // conversion and a long sink stall.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 300;
    localparam int REPORT_LIMIT   = 10;
    localparam int N_DIRECTED     = 20;

    typedef struct packed {
        logic [CHAR_BITS-1:0] digit_char;
        logic                 last;
    } digit_word_t;

    // A directed row: the number and, where it is plain to see, its decimal text.
    // An empty text means the row is checked against the digit predictor instead.
    typedef struct {
        logic [NUMBER_BITS-1:0] number;
        string                  text;
    } directed_row_t;

    directed_row_t directed_rows [N_DIRECTED] = '{
        '{64'd0,                    "0"},
        '{64'd1,                    "1"},
        '{64'd9,                    "9"},
        '{64'd10,                   "10"},
        '{64'd99,                   "99"},
        '{64'd100,                  "100"},
        '{64'd4294967295,           "4294967295"},
        '{64'd4294967296,           "4294967296"},
        '{64'd9223372036854775807,  "9223372036854775807"},
        '{64'd9223372036854775808,  "9223372036854775808"},
        '{64'd9999999999999999999,  "9999999999999999999"},
        '{64'd10000000000000000000, "10000000000000000000"},
        '{64'd12345678901234567890, "12345678901234567890"},
        '{64'd18446744073709551614, "18446744073709551614"},
        '{64'd18446744073709551615, "18446744073709551615"},
        '{64'h5555_5555_5555_5555,  ""},
        '{64'hAAAA_AAAA_AAAA_AAAA,  ""},
        '{64'h8000_0000_0000_0001,  ""},
        '{64'h0123_4567_89AB_CDEF,  ""},
        '{64'd1000000007,           ""}
    };

    logic clk = 1'b0;
    logic rst_n;

    always #6 clk = ~clk;

    bda_number_if number_ch ();
    bda_digit_if  digit_ch ();

    binary_to_decimal_ascii_top #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .number_ch (number_ch),
        .digit_ch  (digit_ch)
    );

    // Digits still owed by the block, oldest first
    digit_word_t pending_digits [$];
    int          error_count = 0;
    int          idle_cycles = 0;
    int          stall_left  = 0;
    // Set for stretches in which neither side idles
    logic        steady;
    // Decimal text of the number on offer, empty when the predictor decides
    string       offered_text;

    function automatic logic [NUMBER_BITS-1:0] ten_to_the(input int n);
        logic [NUMBER_BITS-1:0] p;
        p = 64'd1;
        for (int i = 0; i < n; i++)
            p = p * 64'd10;
        return p;
    endfunction

    function automatic logic [NUMBER_BITS-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Work out the decimal digits of a value and queue them, most significant first
    function automatic void queue_decimal_digits(input logic [NUMBER_BITS-1:0] value);
        logic [NUMBER_BITS-1:0] rest;
        logic [BCD_BITS-1:0]    rev [MAX_DIGITS];
        digit_word_t            w;
        int                     n;
        rest = value & WIDTH_MASK;
        n    = 0;
        do
        begin
            rev[n] = BCD_BITS'(rest % 64'd10);
            rest   = rest / 64'd10;
            n++;
        end
        while (rest != 0 && n < MAX_DIGITS);
        for (int k = 0; k < n; k++)
        begin
            w.digit_char = ASCII_ZERO + CHAR_BITS'(rev[n - 1 - k]);
            w.last       = (k == n - 1);
            pending_digits.push_back(w);
        end
    endfunction

    // Queue the digits spelt out by a typed-in decimal string
    function automatic void queue_digit_text(input string text);
        logic [7:0]  c;
        digit_word_t w;
        for (int i = 0; i < text.len(); i++)
        begin
            c            = text[i];
            w.digit_char = c[CHAR_BITS-1:0];
            w.last       = (i == text.len() - 1);
            pending_digits.push_back(w);
        end
    endfunction

    // Count a failure; only the first few are worth printing
    function automatic void note_failure(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%t: %s", $realtime, msg);
    endfunction

    // Random numbers spread over every digit count, with extra weight near
    // powers of ten and of two, where carries ripple through the digit chain
    function automatic logic [NUMBER_BITS-1:0] random_number();
        int kind;
        kind = $urandom_range(0, 9);
        case (kind)
            3, 4, 5: return random_word() % ten_to_the($urandom_range(1, 19));
            6:       return 64'($urandom_range(0, 20));
            7:       return ten_to_the($urandom_range(1, 19)) - 64'd1
                            + 64'($urandom_range(0, 2));
            8:       return (64'd1 << $urandom_range(1, 63)) - 64'd1
                            + 64'($urandom_range(0, 2));
            9:       return {NUMBER_BITS{1'b1}} - 64'($urandom_range(0, 1000));
            default: return random_word();
        endcase
    endfunction

    // Sink side: hold ready low for stalls, mostly short, now and then long.
    // Drive at the falling edge so the block sees a settled ready at the rising edge.
    always @(negedge clk)
    begin
        if (steady)
            digit_ch.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            digit_ch.ready <= 1'b0;
        end
        else if ($urandom_range(0, 2) != 0)
            digit_ch.ready <= 1'b1;
        else
        begin
            digit_ch.ready <= 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(0, 3);
        end
    end

    // Sample both channels at the rising edge, before the block's own updates land.
    always @(posedge clk)
    begin : channel_monitor
        digit_word_t seen;
        digit_word_t want;
        // Check the outgoing digit first, so a digit can never be matched
        // against the number taken on the very same edge
        if (digit_ch.valid && digit_ch.ready)
        begin
            seen.digit_char = digit_ch.digit_char;
            seen.last       = digit_ch.last;
            if (pending_digits.size() == 0)
                note_failure($sformatf("unexpected digit: char %0d last %b",
                                       seen.digit_char, seen.last));
            else
            begin
                want = pending_digits.pop_front();
                if (seen.digit_char !== want.digit_char || seen.last !== want.last)
                    note_failure($sformatf(
                        "digit mismatch: expected char %0d last %b, got char %0d last %b",
                        want.digit_char, want.last, seen.digit_char, seen.last));
            end
        end
        // A number taken: queue the digits it owes
        if (number_ch.valid && number_ch.ready)
        begin
            if (offered_text.len() != 0)
                queue_digit_text(offered_text);
            else
                queue_decimal_digits(number_ch.number);
        end
        // Watchdog: advance on every edge where no word moves, clear otherwise
        if ((digit_ch.valid && digit_ch.ready) || (number_ch.valid && number_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%t: no word moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one number, after a random gap unless steady, and hold it until the block takes it.
    // Returns at the falling edge after the accepting rising edge.
    task automatic send_number(input logic [NUMBER_BITS-1:0] value, input string text);
        int gap;
        if (steady)
            gap = 0;
        else if ($urandom_range(0, 9) == 0)
            gap = $urandom_range(10, 60);
        else
            gap = $urandom_range(0, 2);
        if (gap > 0)
        begin
            // Drop valid and put junk on the payload while idling
            number_ch.valid  <= 1'b0;
            number_ch.number <= random_word();
            repeat (gap) @(negedge clk);
        end
        number_ch.valid  <= 1'b1;
        number_ch.number <= value;
        offered_text = text;
        @(posedge clk);
        while (!(number_ch.valid && number_ch.ready))
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hold the sender off until every owed digit has come out
    task automatic hold_until_drained();
        number_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_digits.size() != 0);
    endtask

    initial
    begin
        rst_n            = 1'b0;
        number_ch.valid  = 1'b0;
        number_ch.number = '0;
        digit_ch.ready   = 1'b0;
        steady           = 1'b1;
        offered_text     = "";

        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed rows: zero, single digits, the 2-, 3- and 20-digit boundaries, the
        // 32-bit and 63-bit edges and the widest value with its twenty digits.
        // Run the first few with no idling at all, then let both sides idle.
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            steady = (i < 8);
            send_number(directed_rows[i].number, directed_rows[i].text);
        end
        hold_until_drained();

        // Random numbers, in stretches chosen at random to idle or not.
        // Every so often hold the sender back until the block has emptied.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 20 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (i % 75 == 40)
                hold_until_drained();
            send_number(random_number(), "");
        end
        number_ch.valid <= 1'b0;

        // Wait for the last digits, then give stray words a chance to show up
        while (pending_digits.size() != 0)
            @(posedge clk);
        repeat (2 * DIGIT_LATENCY) @(posedge clk);

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: binary_to_decimal_ascii_top.f
rtl/bda_pkg.sv
rtl/bda_number_if.sv
rtl/bda_digit_if.sv
rtl/bda_cell.sv
rtl/binary_to_decimal_ascii_top.sv
bench/binary_to_decimal_ascii_top_test.sv
